FILE: src/assert_macros.svh
// assertion macros for the rtl, included by swd_host_transaction_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising edge outside reset
`define SWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SWD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/swd_pkg.sv
// types, codes and helper functions for the swd host transfer engine
package swd_pkg;

  localparam int LINE_RESET_CLOCKS = 50;
  localparam int BitCntW = 6;
  localparam int LenW = BitCntW + 1;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_READ      = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_LINE_RST  = 3'd3;
  localparam logic [2:0] CMD_RST_SET   = 3'd4;
  localparam logic [2:0] CMD_RST_CLR   = 3'd5;

  localparam logic [2:0] STATUS_OK     = 3'd0;
  localparam logic [2:0] STATUS_WAIT   = 3'd1;
  localparam logic [2:0] STATUS_FAULT  = 3'd2;
  localparam logic [2:0] STATUS_BADACK = 3'd3;
  localparam logic [2:0] STATUS_PARITY = 3'd4;

  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  localparam int HdrLen  = 8;
  localparam int AckLen  = 3;
  localparam int DataLen = 33;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_LRST  = 10'b00_0000_0010,
    PH_LIDLE = 10'b00_0000_0100,
    PH_HDR   = 10'b00_0000_1000,
    PH_TRN1  = 10'b00_0001_0000,
    PH_ACK   = 10'b00_0010_0000,
    PH_TRN2  = 10'b00_0100_0000,
    PH_RDATA = 10'b00_1000_0000,
    PH_WDATA = 10'b01_0000_0000,
    PH_RIDLE = 10'b10_0000_0000
  } phase_t;

  // line drive for a phase: {data, output enable}
  typedef struct packed {
    logic dout;
    logic oe;
  } line_drive_t;

  function automatic logic [LenW-1:0] phase_len(phase_t ph);
    logic [LenW-1:0] len;
    case (ph)
      PH_LRST:  len = LenW'(LINE_RESET_CLOCKS);
      PH_HDR:   len = LenW'(HdrLen);
      PH_ACK:   len = LenW'(AckLen);
      PH_RDATA: len = LenW'(DataLen);
      PH_WDATA: len = LenW'(DataLen);
      default:  len = LenW'(1);
    endcase
    return len;
  endfunction

  function automatic line_drive_t drive(phase_t ph, logic hdr_bit, logic wr_bit);
    line_drive_t d;
    d.dout = 1'b0;
    d.oe   = 1'b1;
    case (ph)
      PH_LRST:  d.dout = 1'b1;
      PH_HDR:   d.dout = hdr_bit;
      PH_WDATA: d.dout = wr_bit;
      PH_TRN1, PH_ACK, PH_TRN2, PH_RDATA: d.oe = 1'b0;
      default:  d.oe = 1'b1;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] ack_to_status(logic [2:0] ack);
    logic [2:0] st;
    case (ack)
      ACK_OK:    st = STATUS_OK;
      ACK_WAIT:  st = STATUS_WAIT;
      ACK_FAULT: st = STATUS_FAULT;
      default:   st = STATUS_BADACK;
    endcase
    return st;
  endfunction

endpackage

FILE: src/swd_host_transaction_engine.sv
// swd host transfer engine: input register, bus step logic, result register
//
// One input transfer is either a command (read, write, line reset, target
// reset set or clear) or a tick that steps the SWD bus by one clock tick.
// Every input transfer yields exactly one result transfer with the line
// levels for that tick, the target reset pin, busy/done flags, the status of
// the last operation and the last good read word.
// Both channels use valid/stall; a transfer moves when valid is high and
// stall is low. An accepted item is evaluated from the input register into
// the result register as soon as the result register is empty or its
// result moves. One item is taken every cycle while the receiver does not
// stall; the only recurrence is the bus state update, which is combinational.
// If the receiver stalls, the result register holds and the input register
// fills; after that in_stall is raised until the result moves. The user must
// write clock_divisor through cfg_wr_en/cfg_wr_data only while the block is
// idle; the block does not enforce it. It is the number of ticks per SWD bit
// period. Synchronous reset empties both registers, parks the bus idle,
// releases the target reset pin and sets clock_divisor to 30.
module swd_host_transaction_engine #(
  parameter int DIVIDER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic        select_ap,
  input  logic [1:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic        swdio_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        swclk,
  output logic        swdio_out,
  output logic        swdio_oe,
  output logic        target_reset,
  output logic        busy_res,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [31:0] read_data
);

  `include "assert_macros.svh"

  localparam int TickW = DIVIDER_BITS;
  localparam int DivW  = DIVIDER_BITS + 1;
  localparam logic [16:0] DivMax = 17'(1) << DIVIDER_BITS;

  // input register
  logic        s1_valid;
  logic [2:0]  s1_cmd;
  logic        s1_ap;
  logic [1:0]  s1_idx;
  logic [31:0] s1_wdata;
  logic        s1_sio;

  // bus state
  logic [16:0]                  clock_divisor;
  swd_pkg::phase_t              phase, phase_next;
  logic [swd_pkg::BitCntW-1:0]  bit_counter, bit_counter_next;
  logic [TickW-1:0]             tick_counter, tick_counter_next;
  logic [32:0]                  out_shift, out_shift_next;
  logic [32:0]                  in_shift, in_shift_next;
  logic [2:0]                   ack_bits, ack_bits_next;
  logic                         is_write_op, is_write_op_next;
  logic                         reset_pin, reset_pin_next;
  logic [31:0]                  read_word, read_word_next;
  logic [2:0]                   last_status, last_status_next;

  logic                  advance;
  logic                  in_accept;
  logic [DivW-1:0]       div_eff;
  logic [DivW-1:0]       tick_ext;
  logic                  bit_end;
  logic                  bit_last;
  logic [2:0]            ack_shifted;
  logic                  hdr_par;
  logic                  res_clk;
  logic                  res_done;
  swd_pkg::line_drive_t  res_drive;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // effective divisor: zero acts as one, large values saturate
  always_comb begin
    if (clock_divisor == 17'd0) begin
      div_eff = DivW'(1);
    end else if (clock_divisor > DivMax) begin
      div_eff = DivW'(DivMax);
    end else begin
      div_eff = clock_divisor[DivW-1:0];
    end
  end

  assign tick_ext    = {1'b0, tick_counter};
  assign bit_end     = tick_ext >= (div_eff - DivW'(1));
  assign bit_last    = ({1'b0, bit_counter} + swd_pkg::LenW'(1)) >= swd_pkg::phase_len(phase);
  assign ack_shifted = {s1_sio, ack_bits[2:1]};
  assign hdr_par     = s1_ap ^ (s1_cmd == swd_pkg::CMD_READ) ^ s1_idx[0] ^ s1_idx[1];

  always_comb begin
    phase_next       = phase;
    bit_counter_next = bit_counter;
    tick_counter_next = tick_counter;
    out_shift_next   = out_shift;
    in_shift_next    = in_shift;
    ack_bits_next    = ack_bits;
    is_write_op_next = is_write_op;
    reset_pin_next   = reset_pin;
    read_word_next   = read_word;
    last_status_next = last_status;
    res_clk          = 1'b0;
    res_done         = 1'b0;
    res_drive        = swd_pkg::drive(phase, in_shift[0], out_shift[0]);

    case (s1_cmd)
      swd_pkg::CMD_TICK: begin
        if (phase != swd_pkg::PH_IDLE) begin
          res_clk = tick_ext >= (div_eff >> 1);
          if (bit_end) begin
            tick_counter_next = '0;
            case (phase)
              swd_pkg::PH_HDR:   in_shift_next = in_shift >> 1;
              swd_pkg::PH_WDATA: out_shift_next = out_shift >> 1;
              swd_pkg::PH_ACK:   ack_bits_next = ack_shifted;
              swd_pkg::PH_RDATA: in_shift_next = {s1_sio, in_shift[32:1]};
              default: ;
            endcase
            if (!bit_last) begin
              bit_counter_next = bit_counter + swd_pkg::BitCntW'(1);
            end else begin
              bit_counter_next = '0;
              case (phase)
                swd_pkg::PH_LRST: phase_next = swd_pkg::PH_LIDLE;
                swd_pkg::PH_LIDLE: begin
                  last_status_next = swd_pkg::STATUS_OK;
                  phase_next = swd_pkg::PH_IDLE;
                  res_done = 1'b1;
                end
                swd_pkg::PH_HDR: begin
                  in_shift_next = '0;
                  phase_next = swd_pkg::PH_TRN1;
                end
                swd_pkg::PH_TRN1: phase_next = swd_pkg::PH_ACK;
                swd_pkg::PH_ACK: begin
                  if (!is_write_op && ack_shifted == swd_pkg::ACK_OK) begin
                    phase_next = swd_pkg::PH_RDATA;
                  end else begin
                    phase_next = swd_pkg::PH_TRN2;
                  end
                end
                swd_pkg::PH_RDATA: phase_next = swd_pkg::PH_TRN2;
                swd_pkg::PH_TRN2: begin
                  if (ack_bits == swd_pkg::ACK_OK) begin
                    phase_next = is_write_op ? swd_pkg::PH_WDATA : swd_pkg::PH_RIDLE;
                  end else begin
                    last_status_next = swd_pkg::ack_to_status(ack_bits);
                    phase_next = swd_pkg::PH_IDLE;
                    res_done = 1'b1;
                  end
                end
                swd_pkg::PH_WDATA: begin
                  last_status_next = swd_pkg::STATUS_OK;
                  phase_next = swd_pkg::PH_IDLE;
                  res_done = 1'b1;
                end
                swd_pkg::PH_RIDLE: begin
                  // parity bit sits above the data word
                  if (in_shift[32] == ^in_shift[31:0]) begin
                    read_word_next = in_shift[31:0];
                    last_status_next = swd_pkg::STATUS_OK;
                  end else begin
                    last_status_next = swd_pkg::STATUS_PARITY;
                  end
                  phase_next = swd_pkg::PH_IDLE;
                  res_done = 1'b1;
                end
                default: phase_next = swd_pkg::PH_IDLE;
              endcase
            end
          end else begin
            tick_counter_next = tick_counter + TickW'(1);
          end
        end
      end
      swd_pkg::CMD_READ, swd_pkg::CMD_WRITE: begin
        if (phase == swd_pkg::PH_IDLE) begin
          is_write_op_next = (s1_cmd == swd_pkg::CMD_WRITE);
          // start, APnDP, RnW, A[3:2], parity, stop, park
          in_shift_next = {25'd0, 1'b1, 1'b0, hdr_par, s1_idx,
                           (s1_cmd == swd_pkg::CMD_READ), s1_ap, 1'b1};
          out_shift_next = (s1_cmd == swd_pkg::CMD_WRITE) ? {^s1_wdata, s1_wdata} : 33'd0;
          ack_bits_next = '0;
          tick_counter_next = '0;
          bit_counter_next = '0;
          phase_next = swd_pkg::PH_HDR;
        end
        res_drive = swd_pkg::drive(phase_next, in_shift_next[0], out_shift_next[0]);
      end
      swd_pkg::CMD_LINE_RST: begin
        if (phase == swd_pkg::PH_IDLE) begin
          tick_counter_next = '0;
          bit_counter_next = '0;
          phase_next = swd_pkg::PH_LRST;
        end
        res_drive = swd_pkg::drive(phase_next, in_shift_next[0], out_shift_next[0]);
      end
      swd_pkg::CMD_RST_SET: reset_pin_next = 1'b1;
      swd_pkg::CMD_RST_CLR: reset_pin_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !advance);
    end
    if (in_accept) begin
      s1_cmd   <= cmd;
      s1_ap    <= select_ap;
      s1_idx   <= reg_index;
      s1_wdata <= write_data;
      s1_sio   <= swdio_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_divisor <= 17'd30;
      phase         <= swd_pkg::PH_IDLE;
      bit_counter   <= '0;
      tick_counter  <= '0;
      out_shift     <= '0;
      in_shift      <= '0;
      ack_bits      <= '0;
      is_write_op   <= 1'b0;
      reset_pin     <= 1'b0;
      read_word     <= '0;
      last_status   <= swd_pkg::STATUS_OK;
    end else begin
      if (cfg_wr_en) begin
        clock_divisor <= cfg_wr_data;
      end
      if (advance) begin
        phase        <= phase_next;
        bit_counter  <= bit_counter_next;
        tick_counter <= tick_counter_next;
        out_shift    <= out_shift_next;
        in_shift     <= in_shift_next;
        ack_bits     <= ack_bits_next;
        is_write_op  <= is_write_op_next;
        reset_pin    <= reset_pin_next;
        read_word    <= read_word_next;
        last_status  <= last_status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
    if (advance) begin
      swclk        <= res_clk;
      swdio_out    <= res_drive.dout;
      swdio_oe     <= res_drive.oe;
      target_reset <= reset_pin_next;
      busy_res     <= (phase_next != swd_pkg::PH_IDLE);
      done_res     <= res_done;
      status       <= last_status_next;
      read_data    <= read_word_next;
    end
  end

  `SWD_ASSERT_IMPL(a_done_not_busy, out_valid && done_res, !busy_res,
    "done reported while still busy")
  `SWD_ASSERT_IMPL(a_clk_only_active, out_valid && swclk, busy_res || done_res,
    "swclk high with no operation running")
  `SWD_ASSERT_IMPL(a_release_only_active, out_valid && !swdio_oe, busy_res || done_res,
    "swdio released while bus idle")
  `SWD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid,
    "evaluated item did not reach the result register")

endmodule

FILE: verif/tb_swd_host_transaction_engine.sv
// self-checking testbench for the swd host transaction engine
`timescale 1ns / 100ps

module tb_swd_host_transaction_engine;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RANDOM_ITEMS = 40;
  localparam int RANDOM_OPS = 1;

  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;
  localparam logic [2:0] ACK_NONE = 3'b000;
  localparam logic [2:0] ACK_ALL = 3'b111;
  localparam logic [2:0] ACK_MIXED = 3'b011;

  localparam logic [16:0] DIV_CAP = 17'd65536;
  localparam logic [16:0] DIV_MAX = 17'h1FFFF;

  typedef struct packed {
    logic        clk_lvl;
    logic        dout;
    logic        oe;
    logic        trst;
    logic        busy;
    logic        done;
    logic [2:0]  st;
    logic [31:0] rdata;
  } line_sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = swd_pkg::CMD_TICK;
  logic        select_ap = 1'b0;
  logic [1:0]  reg_index = '0;
  logic [31:0] write_data = '0;
  logic        swdio_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        swclk;
  logic        swdio_out;
  logic        swdio_oe;
  logic        target_reset;
  logic        busy_res;
  logic        done_res;
  logic [2:0]  status;
  logic [31:0] read_data;

  swd_host_transaction_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .select_ap    (select_ap),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .swdio_in     (swdio_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .swclk        (swclk),
    .swdio_out    (swdio_out),
    .swdio_oe     (swdio_oe),
    .target_reset (target_reset),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .status       (status),
    .read_data    (read_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predicted bus state
  swd_pkg::phase_t bus_phase = swd_pkg::PH_IDLE;
  logic [5:0]  bit_idx = '0;
  logic [15:0] tick_idx = '0;
  logic [32:0] wr_shift = '0;
  logic [32:0] rd_shift = '0;
  logic [2:0]  ack_seen = '0;
  logic        op_is_write = 1'b0;
  logic        pin_asserted = 1'b0;
  logic [31:0] good_word = '0;
  logic [2:0]  op_status = swd_pkg::STATUS_OK;
  logic [16:0] divisor_reg = 17'd30;

  // what the emulated target answers during ack and read data
  logic [2:0]  tgt_ack = swd_pkg::ACK_OK;
  logic [31:0] tgt_word = '0;
  logic        tgt_par_flip = 1'b0;

  line_sample_t pending_lines[$];
  line_sample_t seen_line;
  line_sample_t want_line;

  int idle_mode = 1;
  int stall_left = 0;
  int unsigned quiet_cycles = 0;
  int items_sent = 0;
  int results_checked = 0;
  int ops_done = 0;
  int ops_started = 0;
  int mismatch_count = 0;

  function automatic logic [6:0] bits_in_phase(swd_pkg::phase_t ph);
    logic [6:0] n;
    case (ph)
      swd_pkg::PH_LRST:                     n = 7'(swd_pkg::LINE_RESET_CLOCKS);
      swd_pkg::PH_HDR:                      n = 7'd8;
      swd_pkg::PH_ACK:                      n = 7'd3;
      swd_pkg::PH_RDATA, swd_pkg::PH_WDATA: n = 7'd33;
      default:                              n = 7'd1;
    endcase
    return n;
  endfunction

  function automatic logic [16:0] ticks_per_bit();
    logic [16:0] d;
    d = divisor_reg;
    if (d == 17'd0) d = 17'd1;
    if (d > DIV_CAP) d = DIV_CAP;
    return d;
  endfunction

  // {dout, oe} for the current phase
  function automatic logic [1:0] line_drive_now();
    logic [1:0] drv;
    case (bus_phase)
      swd_pkg::PH_LRST:  drv = 2'b11;
      swd_pkg::PH_HDR:   drv = {rd_shift[0], 1'b1};
      swd_pkg::PH_WDATA: drv = {wr_shift[0], 1'b1};
      swd_pkg::PH_TRN1, swd_pkg::PH_ACK, swd_pkg::PH_TRN2, swd_pkg::PH_RDATA: drv = 2'b00;
      default:           drv = 2'b01;
    endcase
    return drv;
  endfunction

  function automatic logic [2:0] status_of_ack(logic [2:0] a);
    logic [2:0] st;
    case (a)
      swd_pkg::ACK_OK:    st = swd_pkg::STATUS_OK;
      swd_pkg::ACK_WAIT:  st = swd_pkg::STATUS_WAIT;
      swd_pkg::ACK_FAULT: st = swd_pkg::STATUS_FAULT;
      default:            st = swd_pkg::STATUS_BADACK;
    endcase
    return st;
  endfunction

  function automatic void enter_phase(swd_pkg::phase_t p);
    bus_phase = p;
    bit_idx = '0;
  endfunction

  // closes one bit period, returns 1 when the bus operation completes
  function automatic logic close_bit(logic sample);
    logic last;
    logic fin;
    logic [31:0] w;
    fin = 1'b0;
    last = ({1'b0, bit_idx} + 7'd1) >= bits_in_phase(bus_phase);
    case (bus_phase)
      swd_pkg::PH_HDR:   rd_shift = rd_shift >> 1;
      swd_pkg::PH_WDATA: wr_shift = wr_shift >> 1;
      swd_pkg::PH_ACK:   ack_seen = {sample, ack_seen[2:1]};
      swd_pkg::PH_RDATA: rd_shift = {sample, rd_shift[32:1]};
      default:  ;
    endcase
    if (!last) begin
      bit_idx = bit_idx + 6'd1;
    end else begin
      case (bus_phase)
        swd_pkg::PH_LRST:  enter_phase(swd_pkg::PH_LIDLE);
        swd_pkg::PH_LIDLE: begin
          op_status = swd_pkg::STATUS_OK;
          enter_phase(swd_pkg::PH_IDLE);
          fin = 1'b1;
        end
        swd_pkg::PH_HDR: begin
          rd_shift = '0;
          enter_phase(swd_pkg::PH_TRN1);
        end
        swd_pkg::PH_TRN1:  enter_phase(swd_pkg::PH_ACK);
        swd_pkg::PH_ACK: begin
          if (!op_is_write && ack_seen == swd_pkg::ACK_OK) enter_phase(swd_pkg::PH_RDATA);
          else enter_phase(swd_pkg::PH_TRN2);
        end
        swd_pkg::PH_RDATA: enter_phase(swd_pkg::PH_TRN2);
        swd_pkg::PH_TRN2: begin
          if (ack_seen == swd_pkg::ACK_OK) begin
            if (op_is_write) enter_phase(swd_pkg::PH_WDATA);
            else enter_phase(swd_pkg::PH_RIDLE);
          end else begin
            op_status = status_of_ack(ack_seen);
            enter_phase(swd_pkg::PH_IDLE);
            fin = 1'b1;
          end
        end
        swd_pkg::PH_WDATA: begin
          op_status = swd_pkg::STATUS_OK;
          enter_phase(swd_pkg::PH_IDLE);
          fin = 1'b1;
        end
        swd_pkg::PH_RIDLE: begin
          w = rd_shift[31:0];
          if (rd_shift[32] == ^w) begin
            good_word = w;
            op_status = swd_pkg::STATUS_OK;
          end else begin
            op_status = swd_pkg::STATUS_PARITY;
          end
          enter_phase(swd_pkg::PH_IDLE);
          fin = 1'b1;
        end
        default:  enter_phase(swd_pkg::PH_IDLE);
      endcase
    end
    return fin;
  endfunction

  // advances the predicted bus by one item and returns the line levels it shows
  function automatic line_sample_t bus_step(logic [2:0] c, logic ap, logic [1:0] idx,
                                            logic [31:0] wd, logic sio);
    line_sample_t r;
    logic [16:0] d;
    logic [1:0] drv;
    logic fin;
    logic rnw;
    r = '0;
    fin = 1'b0;
    if (c == swd_pkg::CMD_TICK) begin
      drv = line_drive_now();
      if (bus_phase != swd_pkg::PH_IDLE) begin
        d = ticks_per_bit();
        r.clk_lvl = (17'(tick_idx) >= (d >> 1));
        if (17'(tick_idx) >= d - 17'd1) begin
          tick_idx = '0;
          fin = close_bit(sio);
        end else begin
          tick_idx = tick_idx + 16'd1;
        end
      end
    end else begin
      if (c == swd_pkg::CMD_RST_SET) begin
        pin_asserted = 1'b1;
      end else if (c == swd_pkg::CMD_RST_CLR) begin
        pin_asserted = 1'b0;
      end else if (bus_phase == swd_pkg::PH_IDLE &&
                   (c == swd_pkg::CMD_READ || c == swd_pkg::CMD_WRITE)) begin
        rnw = (c == swd_pkg::CMD_READ);
        op_is_write = (c == swd_pkg::CMD_WRITE);
        // park, stop, parity, address, rnw, apndp, start
        rd_shift = {25'd0, 1'b1, 1'b0, ap ^ rnw ^ idx[0] ^ idx[1], idx, rnw, ap, 1'b1};
        wr_shift = op_is_write ? {^wd, wd} : '0;
        ack_seen = '0;
        tick_idx = '0;
        enter_phase(swd_pkg::PH_HDR);
      end else if (bus_phase == swd_pkg::PH_IDLE && c == swd_pkg::CMD_LINE_RST) begin
        tick_idx = '0;
        enter_phase(swd_pkg::PH_LRST);
      end
      drv = line_drive_now();
    end
    r.dout = drv[1];
    r.oe = drv[0];
    r.trst = pin_asserted;
    r.busy = (bus_phase != swd_pkg::PH_IDLE);
    r.done = fin;
    r.st = op_status;
    r.rdata = good_word;
    return r;
  endfunction

  function automatic logic target_level();
    logic lvl;
    case (bus_phase)
      swd_pkg::PH_ACK:   lvl = tgt_ack[bit_idx[1:0]];
      swd_pkg::PH_RDATA: begin
        lvl = (bit_idx < 6'd32) ? tgt_word[bit_idx[4:0]] : (^tgt_word ^ tgt_par_flip);
      end
      default:  lvl = 1'($urandom_range(0, 1));
    endcase
    return lvl;
  endfunction

  function automatic int pick_gap();
    int r;
    int g;
    g = 0;
    r = $urandom_range(0, 99);
    if (idle_mode == 2) begin
      if (r >= 97) g = $urandom_range(1, 3);
    end else if (idle_mode == 1) begin
      if (r >= 93) g = $urandom_range(8, 40);
      else if (r >= 65) g = $urandom_range(1, 3);
    end
    return g;
  endfunction

  function automatic string describe_line(line_sample_t l);
    return $sformatf("clk %b dout %b oe %b trst %b busy %b done %b status %0d data %08h",
                     l.clk_lvl, l.dout, l.oe, l.trst, l.busy, l.done, l.st, l.rdata);
  endfunction

  task automatic issue_item(input logic [2:0] c, input logic ap, input logic [1:0] idx,
                            input logic [31:0] wd, input logic sio);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    select_ap <= ap;
    reg_index <= idx;
    write_data <= wd;
    swdio_in <= sio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_lines.push_back(bus_step(c, ap, idx, wd, sio));
    items_sent++;
  endtask

  task automatic send_cmd(input logic [2:0] c);
    issue_item(c, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom,
               1'($urandom_range(0, 1)));
  endtask

  task automatic tick_once();
    issue_item(swd_pkg::CMD_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
               $urandom, target_level());
  endtask

  // a tick, or now and then a command thrown in while the bus is busy
  task automatic step_bus(input int meddle_pct);
    if (meddle_pct > 0 && $urandom_range(0, 99) < meddle_pct) begin
      send_cmd(3'($urandom_range(1, 7)));
    end else begin
      tick_once();
    end
  endtask

  // stop sending and let every expected result arrive
  task automatic settle_bus();
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [16:0] value);
    settle_bus();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    divisor_reg = value;
  endtask

  task automatic start_bus_op(input logic [2:0] c, input logic ap, input logic [1:0] idx,
                              input logic [31:0] wd, input logic [2:0] ack,
                              input logic [31:0] word, input logic flip);
    tgt_ack = ack;
    tgt_word = word;
    tgt_par_flip = flip;
    issue_item(c, ap, idx, wd, 1'($urandom_range(0, 1)));
    ops_started++;
  endtask

  task automatic finish_bus_op(input int meddle_pct);
    while (bus_phase != swd_pkg::PH_IDLE) step_bus(meddle_pct);
  endtask

  task automatic run_bus_op(input logic [2:0] c, input logic ap, input logic [1:0] idx,
                            input logic [31:0] wd, input logic [2:0] ack,
                            input logic [31:0] word, input logic flip, input int meddle_pct);
    start_bus_op(c, ap, idx, wd, ack, word, flip);
    finish_bus_op(meddle_pct);
  endtask

  task automatic test_idle_and_pin_commands();
    repeat (3) tick_once();
    send_cmd(swd_pkg::CMD_RST_SET);
    repeat (2) tick_once();
    send_cmd(CMD_UNUSED6);
    send_cmd(CMD_UNUSED7);
    send_cmd(swd_pkg::CMD_RST_CLR);
    tick_once();
  endtask

  // divisor still at its reset value here, the read finishes at one tick per bit
  task automatic test_reset_divisor_read();
    start_bus_op(swd_pkg::CMD_READ, 1'b0, 2'd0, $urandom, swd_pkg::ACK_OK, $urandom, 1'b0);
    repeat (40) tick_once();
    write_divisor(17'd1);
    finish_bus_op(0);
  endtask

  task automatic test_line_reset();
    write_divisor(17'd2);
    run_bus_op(swd_pkg::CMD_LINE_RST, 1'b0, 2'd0, $urandom, swd_pkg::ACK_OK, '0, 1'b0, 5);
    write_divisor(17'd1);
    run_bus_op(swd_pkg::CMD_LINE_RST, 1'b1, 2'd3, $urandom, swd_pkg::ACK_OK, '0, 1'b0, 0);
  endtask

  task automatic test_ack_responses();
    logic [2:0] ack_list [0:5];
    int i;
    ack_list[0] = swd_pkg::ACK_OK;
    ack_list[1] = swd_pkg::ACK_WAIT;
    ack_list[2] = swd_pkg::ACK_FAULT;
    ack_list[3] = ACK_NONE;
    ack_list[4] = ACK_ALL;
    ack_list[5] = ACK_MIXED;
    write_divisor(17'd1);
    for (i = 0; i < 6; i++) begin
      run_bus_op(swd_pkg::CMD_READ, 1'(i), 2'(i >> 1), $urandom, ack_list[i], $urandom,
                 1'b0, 0);
    end
    run_bus_op(swd_pkg::CMD_READ, 1'b0, 2'd1, $urandom, swd_pkg::ACK_OK, 32'hFFFF_FFFF,
               1'b0, 0);
    // good ack but the parity bit is wrong
    run_bus_op(swd_pkg::CMD_READ, 1'b1, 2'd2, $urandom, swd_pkg::ACK_OK, $urandom, 1'b1, 0);
    run_bus_op(swd_pkg::CMD_WRITE, 1'b1, 2'd3, 32'hFFFF_FFFF, swd_pkg::ACK_OK, '0, 1'b0, 0);
    run_bus_op(swd_pkg::CMD_WRITE, 1'b0, 2'd2, $urandom, swd_pkg::ACK_WAIT, '0, 1'b0, 0);
    run_bus_op(swd_pkg::CMD_WRITE, 1'b1, 2'd1, $urandom, swd_pkg::ACK_FAULT, '0, 1'b0, 0);
    run_bus_op(swd_pkg::CMD_WRITE, 1'b0, 2'd3, $urandom, ACK_NONE, '0, 1'b0, 0);
  endtask

  task automatic test_divisor_limits();
    // zero behaves as one
    write_divisor(17'd0);
    run_bus_op(swd_pkg::CMD_WRITE, 1'b1, 2'd1, $urandom, swd_pkg::ACK_OK, '0, 1'b0, 0);
    idle_mode = 2;
    // all ones saturates, then the cap itself, then a short divisor mid-bit
    write_divisor(DIV_MAX);
    start_bus_op(swd_pkg::CMD_READ, 1'b0, 2'd3, $urandom, swd_pkg::ACK_OK, $urandom, 1'b0);
    repeat (12) tick_once();
    write_divisor(DIV_CAP);
    repeat (12) tick_once();
    write_divisor(17'd1);
    finish_bus_op(0);
    idle_mode = 1;
  endtask

  task automatic test_random_traffic();
    logic [16:0] div_choices [0:7];
    int start_count;
    int kind;
    int n;
    int meddle;
    logic [2:0] op;
    logic [2:0] ack;
    div_choices[0] = 17'd1;
    div_choices[1] = 17'd1;
    div_choices[2] = 17'd1;
    div_choices[3] = 17'd2;
    div_choices[4] = 17'd2;
    div_choices[5] = 17'd3;
    div_choices[6] = 17'd4;
    div_choices[7] = 17'd7;
    start_count = items_sent;
    n = ops_started;
    while (items_sent - start_count < RANDOM_ITEMS || ops_started - n < RANDOM_OPS) begin
      idle_mode = ($urandom_range(0, 4) == 0) ? 0 : 1;
      if ($urandom_range(0, 2) == 0) write_divisor(div_choices[$urandom_range(0, 7)]);
      kind = $urandom_range(0, 99);
      ack = ($urandom_range(0, 4) != 0) ? swd_pkg::ACK_OK : 3'($urandom_range(0, 7));
      meddle = ($urandom_range(0, 3) == 0) ? 10 : 2;
      if (kind < 40) op = swd_pkg::CMD_READ;
      else if (kind < 75) op = swd_pkg::CMD_WRITE;
      else if (kind < 85) op = swd_pkg::CMD_LINE_RST;
      else op = swd_pkg::CMD_TICK;
      if (op == swd_pkg::CMD_TICK) begin
        // loose commands and ticks, whatever they start gets finished
        repeat ($urandom_range(3, 10)) begin
          issue_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
        end
        finish_bus_op(meddle);
      end else begin
        start_bus_op(op, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom, ack,
                     $urandom, ($urandom_range(0, 6) == 0));
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 40)) begin
            if (bus_phase != swd_pkg::PH_IDLE) step_bus(meddle);
          end
          write_divisor(div_choices[$urandom_range(0, 7)]);
        end
        finish_bus_op(meddle);
      end
    end
    idle_mode = 1;
  endtask

  // receiver side stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_line = {swclk, swdio_out, swdio_oe, target_reset, busy_res, done_res, status,
                   read_data};
      results_checked++;
      if (pending_lines.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: %s", describe_line(seen_line));
        end
      end else begin
        want_line = pending_lines.pop_front();
        if (seen_line !== want_line) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch on result %0d", results_checked);
            $display("  expected %s", describe_line(want_line));
            $display("  actual   %s", describe_line(seen_line));
          end
        end else if (seen_line.done) begin
          ops_done++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_CYCLES) @(posedge clk);
    $display("no transfer for %0d cycles", WATCHDOG_CYCLES);
    $display("swd_host_transaction_engine verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_and_pin_commands();
    test_reset_divisor_read();
    test_line_reset();
    test_ack_responses();
    test_divisor_limits();
    test_random_traffic();
    settle_bus();
    repeat (10) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    $display("%0d reads, writes and line resets started, %0d seen to completion",
             ops_started, ops_done);
    if (mismatch_count == 0 && pending_lines.size() == 0) begin
      $display("swd_host_transaction_engine verification clean");
    end else begin
      $display("swd_host_transaction_engine verification failed");
    end
    $finish;
  end

endmodule
